@@ rtl/ptq_pkg.sv @@
// ----------------------------------------------------------------------------
// ptq_pkg
// Shared types and constants of the two-level priority ticket queue.
// ----------------------------------------------------------------------------
package ptq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W       = ((PTR_W > CNT_W) ? PTR_W : CNT_W) + 1;
  localparam int TICKET_W    = 16;
  localparam int TAG_W       = 16;

  // bit 1 of mode selects a call, bit 0 selects the priority queue on issue
  localparam int MODE_CALL_BIT = 1;
  localparam int MODE_PRIO_BIT = 0;

  localparam logic [TICKET_W-1:0] TICKET_FIRST = TICKET_W'(1);
  localparam logic [TICKET_W-1:0] TICKET_LAST  = {TICKET_W{1'b1}};

  typedef enum logic [1:0] {
    STAT_ISSUED = 2'd0,
    STAT_CALLED = 2'd1,
    STAT_EMPTY  = 2'd2,
    STAT_FULL   = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]       mode;
    logic [TAG_W-1:0] client_tag;
  } in_t;

  typedef struct packed {
    status_t             status;
    logic [TICKET_W-1:0] ticket;
    logic [TAG_W-1:0]    tag_out;
    logic                from_priority;
  } out_t;

  typedef struct packed {
    logic [TICKET_W-1:0] ticket;
    logic [TAG_W-1:0]    tag;
  } entry_t;

  typedef struct packed {
    logic   push;
    logic   pop;
    entry_t wr_data;
  } fifo_cmd_t;

  typedef struct packed {
    logic   empty;
    logic   full;
    entry_t head;
  } fifo_stat_t;

endpackage

@@ rtl/ptq_fifo.sv @@
// ----------------------------------------------------------------------------
// ptq_fifo
// One ticket queue: circular store with head pointer, fill count and a
// registered read of the entry at the head.
// ----------------------------------------------------------------------------
module ptq_fifo
  import ptq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  fifo_cmd_t  cmd,
  output fifo_stat_t stat
);

  entry_t           mem [QUEUE_DEPTH];
  entry_t           head_data_r;
  logic [PTR_W-1:0] head_r;
  logic [PTR_W-1:0] head_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic [SUM_W-1:0] tail_sum;
  logic [PTR_W-1:0] tail;

  always_comb begin
    tail_sum = SUM_W'(head_r) + SUM_W'(count_r);
    if (tail_sum >= SUM_W'(QUEUE_DEPTH)) begin
      tail_sum = tail_sum - SUM_W'(QUEUE_DEPTH);
    end
    tail = tail_sum[PTR_W-1:0];
  end

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    if (cmd.pop) begin
      head_nxt  = (head_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + PTR_W'(1);
      count_nxt = count_r - CNT_W'(1);
    end else if (cmd.push) begin
      count_nxt = count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  // storage and head prefetch; a push into the slot about to be read bypasses
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[tail] <= cmd.wr_data;
    end
    if (cmd.push && (tail == head_nxt)) begin
      head_data_r <= cmd.wr_data;
    end else begin
      head_data_r <= mem[head_nxt];
    end
  end

  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign stat.head  = head_data_r;

endmodule

@@ rtl/ptq_ctrl.sv @@
// ----------------------------------------------------------------------------
// ptq_ctrl
// Request decode, ticket counter, queue selection and result register.
// ----------------------------------------------------------------------------
module ptq_ctrl
  import ptq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       req_valid,
  input  in_t        req,
  input  fifo_stat_t gen_stat,
  input  fifo_stat_t pri_stat,
  output fifo_cmd_t  gen_cmd,
  output fifo_cmd_t  pri_cmd,
  output logic       out_valid,
  output out_t       out_item
);

  logic [TICKET_W-1:0] next_ticket_r;
  logic [TICKET_W-1:0] next_ticket_nxt;
  logic                out_valid_r;
  out_t                out_item_r;
  out_t                out_item_nxt;
  logic                is_call;
  logic                is_prio;
  logic                tgt_full;
  entry_t              new_entry;

  always_comb begin
    is_call   = req.mode[MODE_CALL_BIT];
    is_prio   = req.mode[MODE_PRIO_BIT];
    tgt_full  = is_prio ? pri_stat.full : gen_stat.full;
    new_entry = '{ticket: next_ticket_r, tag: req.client_tag};

    gen_cmd         = '0;
    pri_cmd         = '0;
    gen_cmd.wr_data = new_entry;
    pri_cmd.wr_data = new_entry;
    next_ticket_nxt = next_ticket_r;
    out_item_nxt    = '{status: STAT_EMPTY, ticket: '0, tag_out: '0, from_priority: 1'b0};

    if (is_call) begin
      if (!pri_stat.empty) begin
        pri_cmd.pop  = req_valid;
        out_item_nxt = '{status: STAT_CALLED, ticket: pri_stat.head.ticket,
                         tag_out: pri_stat.head.tag, from_priority: 1'b1};
      end else if (!gen_stat.empty) begin
        gen_cmd.pop  = req_valid;
        out_item_nxt = '{status: STAT_CALLED, ticket: gen_stat.head.ticket,
                         tag_out: gen_stat.head.tag, from_priority: 1'b0};
      end
    end else if (tgt_full) begin
      // dropped, no ticket consumed
      out_item_nxt = '{status: STAT_FULL, ticket: '0, tag_out: '0, from_priority: is_prio};
    end else begin
      pri_cmd.push    = req_valid && is_prio;
      gen_cmd.push    = req_valid && !is_prio;
      out_item_nxt    = '{status: STAT_ISSUED, ticket: next_ticket_r,
                          tag_out: req.client_tag, from_priority: is_prio};
      next_ticket_nxt = (next_ticket_r >= TICKET_LAST) ? TICKET_FIRST
                                                       : next_ticket_r + TICKET_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_ticket_r <= TICKET_FIRST;
      out_valid_r   <= 1'b0;
    end else begin
      out_valid_r <= req_valid;
      if (req_valid) begin
        next_ticket_r <= next_ticket_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

@@ rtl/priority_ticket_queue_top.sv @@
// ----------------------------------------------------------------------------
// priority_ticket_queue_top
// Ticket dispenser with a general and a strict-priority FIFO queue.
//
//   channel   ports                       transfer when
//   -------   -------------------------   ---------------------------
//   request   start, busy, in_item        start high and busy low
//   result    out_valid, out_item         out_valid high, one cycle
//
// One request per cycle while busy is low; each result passes the input
// register, then the queue update and result register.
// busy is high only during reset and the first cycle after it.
// The result side has no back-pressure: each result is valid for a single cycle.
// Queue heads are prefetched from the stores so a call reads them at once.
// ----------------------------------------------------------------------------
module priority_ticket_queue_top
  import ptq_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_item,
  output logic out_valid,
  output out_t out_item
);

  logic       busy_r;
  logic       in_valid_r;
  in_t        in_r;
  fifo_cmd_t  gen_cmd;
  fifo_cmd_t  pri_cmd;
  fifo_stat_t gen_stat;
  fifo_stat_t pri_stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b1;
      in_valid_r <= 1'b0;
    end else begin
      busy_r     <= 1'b0;
      in_valid_r <= start && !busy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      in_r <= in_item;
    end
  end

  assign busy = busy_r;

  ptq_fifo u_gen_fifo (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (gen_cmd),
    .stat (gen_stat)
  );

  ptq_fifo u_pri_fifo (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (pri_cmd),
    .stat (pri_stat)
  );

  ptq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .req_valid(in_valid_r),
    .req      (in_r),
    .gen_stat (gen_stat),
    .pri_stat (pri_stat),
    .gen_cmd  (gen_cmd),
    .pri_cmd  (pri_cmd),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  // every accepted request yields a result after the input and result registers
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##1 out_valid)
    else $error("accepted request produced no result");

  // an issued ticket is never zero
  a_issued_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.status == STAT_ISSUED)) |-> (out_item.ticket != '0))
    else $error("issued ticket is zero");

  // dropped and empty results carry no ticket
  a_no_ticket: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ((out_item.status == STAT_EMPTY) || (out_item.status == STAT_FULL)))
    |-> ((out_item.ticket == '0) && (out_item.tag_out == '0)))
    else $error("ticket reported without a transfer into or out of a queue");

  // nothing waiting never names the priority queue
  a_empty_general: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.status == STAT_EMPTY)) |-> !out_item.from_priority)
    else $error("empty result flagged as priority");

endmodule
